### rtl/olist_pkg.sv
// Shared types and constants for the ordered list unit.
package olist_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int KEY_W          = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DUMP_LD,
        S_OUT
    } t_state;

endpackage

### rtl/ordered_list_insert_search_remove_unit.sv
// Ordered list unit: insertion-ordered list with insert, search, remove and dump.
// Insert: result in the cycle after the request. Search: scan entries in order.
// Remove: scan as search, then shift every later entry down by one place.
// Dump: S_DUMP_LD loads the first entry; then one per cycle while i_out_ready.
// One request at a time; the next is taken once the last result is delivered.
// Synchronous active-low reset empties the list; no clearing pass over storage.
module ordered_list_insert_search_remove_unit #(
    parameter int LIST_DEPTH = olist_pkg::LIST_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_key_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_entry_value,
    output logic               o_entry_valid,
    output logic               o_last_result
);
    import olist_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [KEY_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [KEY_W-1:0] mem_rdata;
    logic [KEY_W-1:0] entry_value;

    olist_mem #(
        .LIST_DEPTH (LIST_DEPTH),
        .AW         (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    olist_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key_value   (i_key_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_entry_value (entry_value),
        .o_entry_valid (o_entry_valid),
        .o_last_result (o_last_result),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    assign o_entry_value = signed'(entry_value);

endmodule

### rtl/olist_mem.sv
// Entry storage: one write port, one read port with registered read data.
module olist_mem #(
    parameter int LIST_DEPTH = olist_pkg::LIST_DEPTH_DEF,
    parameter int AW         = $clog2(LIST_DEPTH)
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [olist_pkg::KEY_W-1:0]    i_wdata,
    input  logic [AW-1:0]                  i_raddr,
    output logic [olist_pkg::KEY_W-1:0]    o_rdata
);
    import olist_pkg::*;

    logic [KEY_W-1:0] r_mem [LIST_DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/olist_ctrl.sv
// Sequencer with shared key compare: scan, shift-down, dump and result register.
module olist_ctrl #(
    parameter int LIST_DEPTH = olist_pkg::LIST_DEPTH_DEF,
    parameter int AW         = $clog2(LIST_DEPTH),
    parameter int CW         = $clog2(LIST_DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_command,
    input  logic [olist_pkg::KEY_W-1:0]    i_key_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [olist_pkg::KEY_W-1:0]    o_entry_value,
    output logic                           o_entry_valid,
    output logic                           o_last_result,
    output logic                           o_mem_we,
    output logic [AW-1:0]                  o_mem_waddr,
    output logic [olist_pkg::KEY_W-1:0]    o_mem_wdata,
    output logic [AW-1:0]                  o_mem_raddr,
    input  logic [olist_pkg::KEY_W-1:0]    i_mem_rdata
);
    import olist_pkg::*;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic             r_dv, n_dv;
    logic [AW-1:0]    r_eidx, n_eidx;
    logic             r_ov, n_ov;
    t_status          r_st, n_st;
    logic [KEY_W-1:0] r_val, n_val;
    logic             r_evld, n_evld;
    logic             r_last, n_last;
    logic             hit;
    logic [CW-1:0]    last_idx;
    logic [CW-1:0]    ptr_nx;

    assign hit      = r_dv && (i_mem_rdata == r_key);
    assign last_idx = r_cnt - CW'(1);
    assign ptr_nx   = r_ptr + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dv    <= n_dv;
            r_ov    <= n_ov;
        end
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        r_ptr  <= n_ptr;
        r_eidx <= n_eidx;
        r_st   <= n_st;
        r_val  <= n_val;
        r_evld <= n_evld;
        r_last <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_dv        = r_dv;
        n_eidx      = r_eidx;
        n_ov        = r_ov;
        n_st        = r_st;
        n_val       = r_val;
        n_evld      = r_evld;
        n_last      = r_last;
        o_in_ready  = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cnt[AW-1:0];
        o_mem_wdata = i_key_value;
        o_mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd  = t_cmd'(i_command);
                    n_key  = i_key_value;
                    n_ptr  = '0;
                    n_dv   = 1'b0;
                    n_val  = '0;
                    n_evld = 1'b0;
                    n_last = 1'b1;
                    n_st   = ST_DONE;
                    unique case (t_cmd'(i_command))
                        CMD_INSERT: begin
                            if (r_cnt == CW'(LIST_DEPTH)) begin
                                n_st = ST_FULL;
                            end else begin
                                o_mem_we = 1'b1;
                                n_cnt    = r_cnt + CW'(1);
                            end
                            n_ov    = 1'b1;
                            n_state = S_OUT;
                        end
                        CMD_SEARCH, CMD_REMOVE: begin
                            n_state = S_SCAN;
                        end
                        CMD_DUMP: begin
                            if (r_cnt == '0) begin
                                n_ov    = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_DUMP_LD;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_mem_raddr = r_ptr[AW-1:0];
                if (hit) begin
                    if (r_cmd == CMD_REMOVE) begin
                        n_ptr   = CW'(r_eidx) + CW'(1);
                        n_dv    = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_st    = ST_DONE;
                        n_ov    = 1'b1;
                        n_state = S_OUT;
                    end
                end else if (r_ptr < r_cnt) begin
                    n_dv   = 1'b1;
                    n_eidx = r_ptr[AW-1:0];
                    n_ptr  = ptr_nx;
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_st    = ST_NOT_FOUND;
                        n_ov    = 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_SHIFT: begin
                o_mem_raddr = r_ptr[AW-1:0];
                if (r_dv) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_eidx - AW'(1);
                    o_mem_wdata = i_mem_rdata;
                end
                if (r_ptr < r_cnt) begin
                    n_dv   = 1'b1;
                    n_eidx = r_ptr[AW-1:0];
                    n_ptr  = ptr_nx;
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_cnt   = r_cnt - CW'(1);
                        n_st    = ST_DONE;
                        n_ov    = 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_DUMP_LD: begin
                n_val       = i_mem_rdata;
                n_evld      = 1'b1;
                n_st        = ST_DONE;
                n_last      = (r_ptr == last_idx);
                n_ov        = 1'b1;
                n_state     = S_OUT;
                o_mem_raddr = ptr_nx[AW-1:0];
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_evld && !r_last) begin
                        n_ptr  = ptr_nx;
                        n_val  = i_mem_rdata;
                        n_last = (ptr_nx == last_idx);
                    end else begin
                        n_ov    = 1'b0;
                        n_state = S_IDLE;
                    end
                end
                o_mem_raddr = n_ptr[AW-1:0] + AW'(1);
            end
            default: begin
                n_state = S_IDLE;
                n_ov    = 1'b0;
            end
        endcase
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_st;
    assign o_entry_value = r_val;
    assign o_entry_valid = r_evld;
    assign o_last_result = r_last;

endmodule
